// ===== sv/ttl_pkg.sv =====
package ttl_pkg;

  localparam int MAP_COLS       = 64;
  localparam int MAP_ROWS       = 32;
  localparam int GLYPH_BYTES    = 131072;
  localparam int COLOUR_ENTRIES = 32768;

  localparam int MAP_DEPTH   = MAP_COLS * MAP_ROWS;
  localparam int MAP_AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int GLYPH_AW    = $clog2(GLYPH_BYTES);
  localparam int GLYPH_TILES = GLYPH_BYTES / 128;
  localparam int COLOUR_AW   = $clog2(COLOUR_ENTRIES);

  localparam int ADDR_W = 17;
  localparam int DATA_W = 24;
  localparam int X_W    = 10;
  localparam int Y_W    = 9;
  localparam int GROUP_W = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] BLANK_ENTRY = 16'h03BF;
  localparam logic [3:0]  PEN_CLEAR   = 4'h0;
  localparam logic [3:0]  PEN_HOLE    = 4'hF;

  typedef enum logic [1:0] {
    FUNC_MAP_WR    = 2'd0,
    FUNC_GLYPH_WR  = 2'd1,
    FUNC_COLOUR_WR = 2'd2,
    FUNC_RENDER    = 2'd3
  } func_e;

  // One classified item waiting for the back end.
  typedef struct packed {
    func_e               func;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    logic [MAP_AW-1:0]   map_idx;
    logic                outside;
    logic [3:0]          fx;
    logic [3:0]          fy;
  } item_t;

endpackage

// ===== sv/ttl_front.sv =====
module ttl_front (
  input  logic                       valid_i,
  input  logic                       full_i,
  input  logic [1:0]                 func_i,
  input  logic [ttl_pkg::ADDR_W-1:0] store_addr_i,
  input  logic [ttl_pkg::DATA_W-1:0] store_data_i,
  input  logic [ttl_pkg::X_W-1:0]    pixel_x_i,
  input  logic [ttl_pkg::Y_W-1:0]    pixel_y_i,
  output logic                       push_o,
  output ttl_pkg::item_t             item_o
);
  import ttl_pkg::*;

  func_e           func;
  logic [5:0]      col;
  logic [4:0]      row;
  logic            drop;

  assign func = func_e'(func_i);
  assign col  = pixel_x_i[X_W-1:4];
  assign row  = pixel_y_i[Y_W-1:4];

  // Drop writes that fall beyond their store; they leave no trace.
  always_comb begin
    case (func)
      FUNC_MAP_WR:    drop = !(32'(store_addr_i) < MAP_DEPTH);
      FUNC_GLYPH_WR:  drop = !(32'(store_addr_i) < GLYPH_BYTES);
      FUNC_COLOUR_WR: drop = !(32'(store_addr_i) < COLOUR_ENTRIES);
      default:        drop = 1'b0;
    endcase
  end

  assign push_o = valid_i && !full_i && !drop;

  always_comb begin
    item_o.func    = func;
    item_o.addr    = store_addr_i;
    item_o.data    = store_data_i;
    item_o.outside = !(32'(col) < MAP_COLS) || !(32'(row) < MAP_ROWS);
    item_o.map_idx = MAP_AW'(32'(row) * MAP_COLS + 32'(col));
    item_o.fx      = pixel_x_i[3:0];
    item_o.fy      = pixel_y_i[3:0];
  end

endmodule

// ===== sv/ttl_queue.sv =====
module ttl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ttl_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           avail_o,
  output ttl_pkg::item_t head_o
);
  import ttl_pkg::*;

  item_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_PW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QUEUE_PW+1)'(QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== sv/ttl_back.sv =====
module ttl_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  ttl_pkg::item_t              head_i,
  output logic                        pop_o,
  input  logic [ttl_pkg::GROUP_W-1:0] palette_group_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic                        opaque_o
);
  import ttl_pkg::*;

  logic [15:0] map_mem    [MAP_DEPTH];
  logic [7:0]  glyph_mem  [GLYPH_BYTES];
  logic [23:0] colour_mem [COLOUR_ENTRIES];

  logic adv;

  // Glyph stage registers.
  logic              g_v_q;
  func_e             g_func_q;
  logic [ADDR_W-1:0] g_addr_q;
  logic [DATA_W-1:0] g_data_q;
  logic              g_outside_q;
  logic [3:0]        g_fx_q, g_fy_q;
  logic [15:0]       g_entry_q;

  // Colour stage registers.
  logic              c_v_q;
  func_e             c_func_q;
  logic [ADDR_W-1:0] c_addr_q;
  logic [DATA_W-1:0] c_data_q;
  logic              c_clear_q;
  logic [3:0]        c_bank_q;
  logic              c_odd_q;
  logic [7:0]        c_byte_q;

  // Output stage registers.
  logic              o_v_q;
  logic              o_clear_q;
  logic              o_oor_q;
  logic [23:0]       o_rgb_q;

  // Decode of the map entry.
  logic [3:0]        fx_eff, fy_eff;
  logic [9:0]        tile;
  logic              g_clear;
  logic [16:0]       glyph_full;

  // Pen and palette index.
  logic [3:0]        pen;
  logic              c_clear;
  logic [15:0]       cidx;
  logic              c_oor;

  // Hold the whole back end while a finished pixel waits.
  assign adv   = !(o_v_q && out_stall_i);
  assign pop_o = adv && avail_i;

  // Map stage: write or read the tile map for the head item.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (pop_o && head_i.func == FUNC_MAP_WR) begin
        map_mem[head_i.addr[MAP_AW-1:0]] <= head_i.data[15:0];
      end
      g_entry_q   <= map_mem[head_i.map_idx];
      g_func_q    <= head_i.func;
      g_addr_q    <= head_i.addr;
      g_data_q    <= head_i.data;
      g_outside_q <= head_i.outside;
      g_fx_q      <= head_i.fx;
      g_fy_q      <= head_i.fy;
    end
  end

  always_comb begin
    tile       = g_entry_q[9:0];
    fx_eff     = g_entry_q[10] ? ~g_fx_q : g_fx_q;
    fy_eff     = g_entry_q[11] ? ~g_fy_q : g_fy_q;
    g_clear    = g_outside_q || (g_entry_q == '0) || (g_entry_q == BLANK_ENTRY)
                 || !(32'(tile) < GLYPH_TILES);
    glyph_full = {tile, fy_eff, fx_eff[3:1]};
  end

  // Glyph stage: write or read one graphics byte.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (g_v_q && g_func_q == FUNC_GLYPH_WR) begin
        glyph_mem[g_addr_q[GLYPH_AW-1:0]] <= g_data_q[7:0];
      end
      c_byte_q  <= glyph_mem[glyph_full[GLYPH_AW-1:0]];
      c_func_q  <= g_func_q;
      c_addr_q  <= g_addr_q;
      c_data_q  <= g_data_q;
      c_clear_q <= g_clear;
      c_bank_q  <= g_entry_q[15:12];
      c_odd_q   <= fx_eff[0];
    end
  end

  always_comb begin
    pen     = c_odd_q ? c_byte_q[3:0] : c_byte_q[7:4];
    c_clear = c_clear_q || (pen == PEN_CLEAR) || (pen == PEN_HOLE);
    cidx    = 16'({palette_group_i, 8'h00}) + 16'({c_bank_q, pen});
    c_oor   = !(32'(cidx) < COLOUR_ENTRIES);
  end

  // Colour stage: write or read the palette.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (c_v_q && c_func_q == FUNC_COLOUR_WR) begin
        colour_mem[c_addr_q[COLOUR_AW-1:0]] <= c_data_q;
      end
      o_rgb_q   <= colour_mem[cidx[COLOUR_AW-1:0]];
      o_clear_q <= c_clear;
      o_oor_q   <= c_oor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (adv) begin
      g_v_q <= pop_o;
      c_v_q <= g_v_q;
      o_v_q <= c_v_q && (c_func_q == FUNC_RENDER);
    end
  end

  assign out_valid_o = o_v_q;
  assign opaque_o    = !o_clear_q;
  assign red_o       = (o_clear_q || o_oor_q) ? 8'h00 : o_rgb_q[7:0];
  assign green_o     = (o_clear_q || o_oor_q) ? 8'h00 : o_rgb_q[15:8];
  assign blue_o      = (o_clear_q || o_oor_q) ? 8'h00 : o_rgb_q[23:16];

endmodule

// ===== sv/tile_text_layer_pixel_gen.sv =====
// A render item passes the queue and the map, graphics and palette stage registers before out_valid_o rises.
// Throughput: one item per cycle while no finished pixel is held at the output.
// A held pixel freezes the back end; the 4-entry queue then fills and stalls the input.
// Write items produce no result and pass the same stages so they stay in order with renders.
// Reset (rst_ni low, asynchronous) empties the queue and pipeline and clears palette_group;
// the three stores keep whatever they held and are undefined until written.
module tile_text_layer_pixel_gen (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [ttl_pkg::ADDR_W-1:0]  store_addr_i,
  input  logic [ttl_pkg::DATA_W-1:0]  store_data_i,
  input  logic [ttl_pkg::X_W-1:0]     pixel_x_i,
  input  logic [ttl_pkg::Y_W-1:0]     pixel_y_i,
  // Palette group register
  input  logic                        cfg_we_i,
  input  logic [ttl_pkg::GROUP_W-1:0] cfg_data_i,
  // Pixel channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic                        opaque_o
);
  import ttl_pkg::*;

  logic [GROUP_W-1:0] palette_group_q;

  logic  push;
  logic  pop;
  logic  full;
  logic  avail;
  item_t front_item;
  item_t head;

  // Palette group base; the user must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_group_q <= '0;
    end else if (cfg_we_i) begin
      palette_group_q <= cfg_data_i;
    end
  end

  // Stall the item channel only when the queue has no room.
  assign in_stall_o = full;

  // Front end: classify, locate the tile and drop out-of-range writes.
  ttl_front u_front (
    .valid_i      (in_valid_i),
    .full_i       (full),
    .func_i       (func_i),
    .store_addr_i (store_addr_i),
    .store_data_i (store_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .push_o       (push),
    .item_o       (front_item)
  );

  // Short queue lets the front keep taking items while the output is held.
  ttl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (full),
    .avail_o (avail),
    .head_o  (head)
  );

  // Back end: map, graphics and palette stages, then the output register.
  ttl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .avail_i         (avail),
    .head_i          (head),
    .pop_o           (pop),
    .palette_group_i (palette_group_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .opaque_o        (opaque_o)
  );

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttl_pkg::*;

  // Cycles to let write items clear the pipeline before a register write.
  localparam int unsigned DRAIN_CYCLES    = 12;
  // Receiver hold-off during the backpressure test.
  localparam int unsigned HOLDOFF_CYCLES  = 100;
  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int unsigned WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       opaque;
  } pixel_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          func_i;
  logic [ADDR_W-1:0]   store_addr_i;
  logic [DATA_W-1:0]   store_data_i;
  logic [X_W-1:0]      pixel_x_i;
  logic [Y_W-1:0]      pixel_y_i;
  logic                cfg_we_i;
  logic [GROUP_W-1:0]  cfg_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          red_o;
  logic [7:0]          green_o;
  logic [7:0]          blue_o;
  logic                opaque_o;

  // Mirror of the block's stores; the known flags track which entries were written,
  // so that no render result ever depends on an entry that holds nothing defined.
  logic [15:0]         map_mirror    [MAP_DEPTH];
  bit                  map_known     [MAP_DEPTH];
  logic [7:0]          glyph_mirror  [GLYPH_BYTES];
  bit                  glyph_known   [GLYPH_BYTES];
  logic [23:0]         colour_mirror [COLOUR_ENTRIES];
  bit                  colour_known  [COLOUR_ENTRIES];
  logic [GROUP_W-1:0]  group_mirror;

  pixel_t              expected_pixels[$];

  int unsigned         items_sent;
  int unsigned         renders_sent;
  int unsigned         pixels_checked;
  int unsigned         opaque_seen;
  int unsigned         input_held_cycles;
  int unsigned         failures;
  bit                  tx_idle_on;
  bit                  rx_idle_on;
  bit                  holdoff_req;

  always #5 clk_i = ~clk_i;

  tile_text_layer_pixel_gen DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .store_addr_i (store_addr_i),
    .store_data_i (store_data_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .opaque_o     (opaque_o)
  );

  // Walk the pixel through map, graphics and palette as the block does.
  // Return FUNC_RENDER when every read hits a written entry (px then holds the
  // colour); otherwise return the write that must come first and its address.
  function automatic func_e trace_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                        output pixel_t px, output int unsigned miss_addr);
    int unsigned col;
    int unsigned row;
    int unsigned map_addr;
    int unsigned tile_base;
    int unsigned glyph_addr;
    int unsigned colour_idx;
    logic [15:0] entry;
    logic [3:0]  fx;
    logic [3:0]  fy;
    logic [3:0]  pen;
    logic [23:0] rgb;
    px        = '0;
    miss_addr = 0;
    col = int'(x) >> 4;
    row = int'(y) >> 4;
    if (col >= MAP_COLS || row >= MAP_ROWS) return FUNC_RENDER;
    map_addr = row * MAP_COLS + col;
    if (!map_known[map_addr]) begin
      miss_addr = map_addr;
      return FUNC_MAP_WR;
    end
    entry = map_mirror[map_addr];
    if (entry == 16'h0000 || entry == BLANK_ENTRY) return FUNC_RENDER;
    fx = x[3:0];
    fy = y[3:0];
    if (entry[10]) fx = 4'hF - fx;
    if (entry[11]) fy = 4'hF - fy;
    tile_base = int'(entry[9:0]) * 128;
    if (tile_base + 128 > GLYPH_BYTES) return FUNC_RENDER;
    glyph_addr = tile_base + int'(fy) * 8 + int'(fx[3:1]);
    if (!glyph_known[glyph_addr]) begin
      miss_addr = glyph_addr;
      return FUNC_GLYPH_WR;
    end
    // High nibble is the left pixel of the pair.
    pen = fx[0] ? glyph_mirror[glyph_addr][3:0] : glyph_mirror[glyph_addr][7:4];
    if (pen == PEN_CLEAR || pen == PEN_HOLE) return FUNC_RENDER;
    colour_idx = (int'(group_mirror) << 8) + int'(entry[15:12]) * 16 + int'(pen);
    px.opaque = 1'b1;
    // An index past the palette draws opaque black.
    if (colour_idx < COLOUR_ENTRIES) begin
      if (!colour_known[colour_idx]) begin
        miss_addr = colour_idx;
        return FUNC_COLOUR_WR;
      end
      rgb      = colour_mirror[colour_idx];
      px.red   = rgb[7:0];
      px.green = rgb[15:8];
      px.blue  = rgb[23:16];
    end
    return FUNC_RENDER;
  endfunction

  // Map entry with a bias toward a handful of tiles and the two blank codes.
  function automatic logic [15:0] random_entry();
    logic [15:0] e;
    e = 16'($urandom());
    case ($urandom_range(9))
      0:             e = 16'h0000;
      1:             e = BLANK_ENTRY;
      2, 3, 4, 5, 6: e[9:0] = 10'($urandom_range(7));
      default: ;
    endcase
    return e;
  endfunction

  // Most pixels fall in the top-left 8x4 tiles so that entries get reused.
  function automatic logic [X_W-1:0] pick_x();
    return ($urandom_range(9) < 7) ? X_W'($urandom_range(127)) : X_W'($urandom());
  endfunction

  function automatic logic [Y_W-1:0] pick_y();
    return ($urandom_range(9) < 7) ? Y_W'($urandom_range(63)) : Y_W'($urandom());
  endfunction

  // Offer one item and hold it until accepted; then update the mirror or queue the pixel.
  task automatic send_item(func_e fn, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data,
                           logic [X_W-1:0] x, logic [Y_W-1:0] y);
    pixel_t      px;
    int unsigned unused_addr;
    while (tx_idle_on && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    store_addr_i <= addr;
    store_data_i <= data;
    pixel_x_i    <= x;
    pixel_y_i    <= y;
    do begin
      @(posedge clk_i);
      if (in_stall_o) input_held_cycles++;
    end while (in_stall_o);
    items_sent++;
    case (fn)
      FUNC_MAP_WR: if (addr < MAP_DEPTH) begin
        map_mirror[addr] = data[15:0];
        map_known[addr]  = 1'b1;
      end
      FUNC_GLYPH_WR: if (addr < GLYPH_BYTES) begin
        glyph_mirror[addr] = data[7:0];
        glyph_known[addr]  = 1'b1;
      end
      FUNC_COLOUR_WR: if (addr < COLOUR_ENTRIES) begin
        colour_mirror[addr] = data;
        colour_known[addr]  = 1'b1;
      end
      default: begin
        void'(trace_pixel(x, y, px, unused_addr));
        expected_pixels.push_back(px);
        renders_sent++;
      end
    endcase
  endtask

  // Write item with random, ignored pixel fields.
  task automatic write_store(func_e fn, int unsigned addr, int unsigned data);
    send_item(fn, ADDR_W'(addr), DATA_W'(data), X_W'($urandom()), Y_W'($urandom()));
  endtask

  // Fill whatever the pixel reads that was never written, then render it.
  task automatic render_at(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    pixel_t      px;
    int unsigned miss;
    func_e       need;
    need = trace_pixel(x, y, px, miss);
    while (need != FUNC_RENDER) begin
      if (need == FUNC_MAP_WR) write_store(need, miss, random_entry());
      else write_store(need, miss, $urandom());
      need = trace_pixel(x, y, px, miss);
    end
    send_item(FUNC_RENDER, ADDR_W'($urandom()), DATA_W'($urandom()), x, y);
  endtask

  // Drop valid, wait for every pixel, then let trailing writes leave the pipeline.
  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_group(logic [GROUP_W-1:0] g);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= g;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    group_mirror  = g;
  endtask

  task automatic test_directed();
    set_group(7'd0);
    // Bank 15, no flips, last tile; left pen 1, right pen 2.
    write_store(FUNC_MAP_WR, 0, 24'hFFF3FF);
    write_store(FUNC_GLYPH_WR, 1023 * 128, 24'h000012);
    write_store(FUNC_COLOUR_WR, 'hF1, 24'hFFFFFF);
    write_store(FUNC_COLOUR_WR, 'hF2, 24'h000000);
    render_at(0, 0);
    render_at(1, 0);
    // Writes past the end of the map and of the palette must be dropped.
    write_store(FUNC_MAP_WR, MAP_DEPTH, 24'h001234);
    write_store(FUNC_COLOUR_WR, COLOUR_ENTRIES + 'hF1, 24'hABCDEF);
    render_at(0, 0);
    // Both blank map codes.
    write_store(FUNC_MAP_WR, 1, 24'h000000);
    render_at(16, 0);
    write_store(FUNC_MAP_WR, 2, BLANK_ENTRY);
    render_at(32, 0);
    // Both flips on tile 5: the flipped corner lands on pen 15, its neighbor on pen 0.
    write_store(FUNC_MAP_WR, 3, 24'hFF0C05);
    write_store(FUNC_GLYPH_WR, 5 * 128, 24'h0000F0);
    render_at(63, 15);
    render_at(62, 15);
    render_at(48, 0);
    // Far corner of the layer.
    render_at(1023, 511);
    render_at(1022, 510);
    // Top palette group.
    set_group(7'd127);
    render_at(0, 0);
    render_at(1, 0);
  endtask

  task automatic test_random_mix(int unsigned quota);
    int unsigned stop_at;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2: begin
          if ($urandom_range(9) < 8)
            write_store(FUNC_MAP_WR, $urandom_range(3) * MAP_COLS + $urandom_range(7),
                        random_entry());
          else write_store(FUNC_MAP_WR, $urandom(), $urandom());
        end
        3, 4, 5: begin
          if ($urandom_range(9) < 7) write_store(FUNC_GLYPH_WR, $urandom_range(1023), $urandom());
          else write_store(FUNC_GLYPH_WR, $urandom(), $urandom());
        end
        6, 7, 8: begin
          if ($urandom_range(9) < 7)
            write_store(FUNC_COLOUR_WR, (int'(group_mirror) << 8) + $urandom_range(255),
                        $urandom());
          else write_store(FUNC_COLOUR_WR, $urandom(), $urandom());
        end
        default: render_at(pick_x(), pick_y());
      endcase
    end
  endtask

  // Hold the pixel side off while renders keep coming, so the block backs up.
  task automatic test_backpressure();
    settle();
    tx_idle_on  = 1'b0;
    holdoff_req = 1'b1;
    repeat (40) render_at(pick_x(), pick_y());
    tx_idle_on  = 1'b1;
  endtask

  // Long stretch with no idling on either side.
  task automatic test_steady_stream(int unsigned quota);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_mix(quota);
    settle();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Pixel side: random stalls, or a counted hold-off when one is requested.
  initial begin : pixel_side
    int unsigned hold_left;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        hold_left   = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= rx_idle_on && ($urandom_range(99) < 16);
      end
    end
  end

  // Compare each accepted pixel with the oldest pending render.
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel with no render pending: r=%0h g=%0h b=%0h opaque=%0b",
               red_o, green_o, blue_o, opaque_o);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want.opaque) opaque_seen++;
        if (red_o !== want.red) begin
          $error("red: expected %0h, got %0h", want.red, red_o);
          failures++;
        end
        if (green_o !== want.green) begin
          $error("green: expected %0h, got %0h", want.green, green_o);
          failures++;
        end
        if (blue_o !== want.blue) begin
          $error("blue: expected %0h, got %0h", want.blue, blue_o);
          failures++;
        end
        if (opaque_o !== want.opaque) begin
          $error("opaque: expected %0b, got %0b", want.opaque, opaque_o);
          failures++;
        end
      end
    end
  end

  // Abandon the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout after %0d quiet cycles, %0d pixels outstanding",
             quiet_cycles, expected_pixels.size());
    $display("tile_text_layer_pixel_gen: mismatch");
    $finish;
  end

  initial begin : run
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    func_i       <= FUNC_MAP_WR;
    store_addr_i <= '0;
    store_data_i <= '0;
    pixel_x_i    <= '0;
    pixel_y_i    <= '0;
    cfg_we_i     <= 1'b0;
    cfg_data_i   <= '0;
    group_mirror  = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    holdoff_req   = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_group(GROUP_W'($urandom()));
    test_random_mix(500);
    test_backpressure();
    set_group(7'd127);
    test_steady_stream(400);
    set_group(7'd1);
    test_random_mix(450);
    settle();

    $display("covered %0d items, %0d renders, %0d pixels checked (%0d opaque)",
             items_sent, renders_sent, pixels_checked, opaque_seen);
    $display("palette groups 0, 127, 1 and one random; input held back %0d cycles",
             input_held_cycles);
    if (failures == 0 && expected_pixels.size() == 0) begin
      $display("tile_text_layer_pixel_gen: match");
    end else begin
      $display("tile_text_layer_pixel_gen: mismatch");
    end
    $finish;
  end

endmodule
